// ===== rtl/kb64_pkg.sv =====
// Shared types, constants and lookup functions for the keyed base64 decoder.
package kb64_pkg;

    localparam logic [7:0] KEY_LEN  = 8'd73;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR = 3'd1;
    localparam logic [2:0] ST_PADS     = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // 72 key characters followed by a zero byte, first character in the top byte
    localparam logic [8*73-1:0] KEY_ROM =
        {"~!:?$*<(qw2e5o7i8x12c6m67s98w43d2l45we82q3iuu1z4xle23rt4oxclle34e54u6r8m", 8'h00};

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       is_status;
        logic [2:0] status;
    } t_res;

    // {valid, 6-bit value}
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'd65;
            return {1'b1, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'd71;
            return {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'd4;
            return {1'b1, d[5:0]};
        end else if (c == 8'h2B) begin
            return {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b1, 6'd63};
        end
        return {1'b0, d[5:0]};
    endfunction

    function automatic logic [7:0] key_byte(input logic [7:0] i);
        logic [9:0] base;
        base = 10'd576 - {i[6:0], 3'b000};
        if (i < KEY_LEN) begin
            return KEY_ROM[base +: 8];
        end
        return 8'h00;
    endfunction

endpackage

// ===== rtl/kb64_core.sv =====
// Decode state and per-request character processing: mapping, pad and error tracking, key XOR.
module kb64_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_char,
    input  logic             i_is_end,
    output kb64_pkg::t_res   o_res
);

    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic [1:0]  r_pad, n_pad;
    logic [6:0]  r_idx, n_idx;
    logic [2:0]  r_err, n_err;

    logic [6:0]  dec;
    logic [5:0]  val;
    logic [1:0]  pad_new;
    logic [1:0]  nb;
    logic [23:0] acc_sh;
    logic [7:0]  idx8;
    kb64_pkg::t_res res;

    assign idx8 = {1'b0, r_idx};

    // results of the presented request; state moves only when it is accepted
    always_comb begin
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_pad   = r_pad;
        n_idx   = r_idx;
        n_err   = r_err;
        res     = '0;
        dec     = kb64_pkg::char_value(i_in_char);
        val     = dec[5:0];
        pad_new = r_pad;
        nb      = 2'd3 - r_pad;
        acc_sh  = r_acc;
        if (i_is_end) begin
            res.cnt       = 2'd1;
            res.is_status = 1'b1;
            res.status    = (r_err == kb64_pkg::ST_OK && r_pos != 2'd0) ?
                            kb64_pkg::ST_BAD_LEN : r_err;
            n_acc = '0;
            n_pos = '0;
            n_pad = '0;
            n_idx = '0;
            n_err = kb64_pkg::ST_OK;
        end else if (r_err == kb64_pkg::ST_OK) begin
            if (i_in_char == kb64_pkg::CHAR_PAD) begin
                if (r_pad >= 2'd2) begin
                    n_err = kb64_pkg::ST_PADS;
                end else begin
                    pad_new = r_pad + 2'd1;
                    val     = 6'd0;
                end
            end else if (!dec[6]) begin
                n_err = kb64_pkg::ST_BAD_CHAR;
            end
            if (n_err == kb64_pkg::ST_OK) begin
                acc_sh = {r_acc[17:0], val};
                n_acc  = acc_sh;
                n_pad  = pad_new;
                nb     = 2'd3 - pad_new;
                if (r_pos != 2'd3) begin
                    n_pos = r_pos + 2'd1;
                end else if (idx8 + {6'd0, nb} > kb64_pkg::KEY_LEN) begin
                    n_err = kb64_pkg::ST_TOO_LONG;
                end else begin
                    res.cnt = nb;
                    res.b0  = acc_sh[23:16] ^ kb64_pkg::key_byte(idx8);
                    res.b1  = acc_sh[15:8]  ^ kb64_pkg::key_byte(idx8 + 8'd1);
                    res.b2  = acc_sh[7:0]   ^ kb64_pkg::key_byte(idx8 + 8'd2);
                    n_idx   = r_idx + {5'd0, nb};
                    n_acc   = '0;
                    n_pos   = '0;
                    n_pad   = '0;
                end
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pos <= '0;
            r_pad <= '0;
            r_idx <= '0;
            r_err <= kb64_pkg::ST_OK;
        end else if (i_accept) begin
            r_acc <= n_acc;
            r_pos <= n_pos;
            r_pad <= n_pad;
            r_idx <= n_idx;
            r_err <= n_err;
        end
    end

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_idx} <= kb64_pkg::KEY_LEN)
        else $error("output index past key length");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != kb64_pkg::ST_OK && !(i_accept && i_is_end)) |=> $stable(r_err))
        else $error("error code changed before end request");
`endif

endmodule

// ===== rtl/kb64_outq.sv =====
// Three-entry result buffer that hands decoded bytes or status out one per cycle while i_stall is low.
module kb64_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kb64_pkg::t_res   i_res,
    input  logic             i_stall,
    output logic             o_can_take,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_is_status,
    output logic [2:0]       o_status
);

    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_b0, r_b1, r_b2;
    logic       r_is_st;
    logic [2:0] r_st;
    logic       pop;
    logic       push;

    assign pop        = (r_cnt != 2'd0) && !i_stall;
    assign push       = (i_res.cnt != 2'd0);
    assign o_can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_comb begin
        n_cnt = r_cnt;
        if (push) begin
            n_cnt = i_res.cnt;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_b0    <= i_res.b0;
            r_b1    <= i_res.b1;
            r_b2    <= i_res.b2;
            r_is_st <= i_res.is_status;
            r_st    <= i_res.status;
        end else if (pop) begin
            r_b0 <= r_b1;
            r_b1 <= r_b2;
        end
    end

    assign o_valid     = (r_cnt != 2'd0);
    assign o_out_byte  = r_b0;
    assign o_is_status = r_is_st;
    assign o_status    = r_st;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("results loaded over pending entries");

    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0 && r_is_st) |-> (r_cnt == 2'd1))
        else $error("status result shares buffer with data");
`endif

endmodule

// ===== rtl/keyed_base64_decoder.sv =====
// Top level of the keyed base64 decoder: character decode core and result buffer.
// Latency: a request's first result is presented the cycle after it is accepted.
// Throughput: one character per cycle; only a request that yields results can stall,
// and only while the buffer holds any result that is not leaving this cycle
// (an end request right after a three-byte group waits until the group's last byte is leaving).
// Results leave at one per cycle unless i_stall is high.
// Reset (synchronous, active low) clears decode state and empties the result buffer.
module keyed_base64_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_char,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_status,
    output logic [2:0] o_status,
    output logic       o_last
);

    kb64_pkg::t_res res;
    kb64_pkg::t_res push_res;
    logic           can_take;
    logic           accept;

    assign o_stall  = (res.cnt != 2'd0) && !can_take;
    assign accept   = i_valid && !o_stall;
    assign push_res = accept ? res : '0;

    kb64_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_char (i_in_char),
        .i_is_end  (i_is_end),
        .o_res     (res)
    );

    kb64_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (push_res),
        .i_stall     (i_stall),
        .o_can_take  (can_take),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status)
    );

    assign o_last = o_is_status;

endmodule
